// File: hw/rtl/assert_macros.svh
// assertion helpers, both clocked on clk and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rau_pkg.sv
package rau_pkg;

  localparam int DW = 64;
  localparam int CW = $clog2(DW + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_NEG  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  localparam logic [4:0] PC_ADD  = 5'd8;
  localparam logic [4:0] PC_SWAP = 5'd20;
  localparam logic [4:0] PC_MUL  = 5'd21;

  typedef enum logic [2:0] {
    SEL_AN, SEL_AD, SEL_BN, SEL_BD, SEL_G1, SEL_G2, SEL_T, SEL_U
  } sel_t;

  typedef enum logic [2:0] {
    K_GCD, K_DIV, K_MUL, K_ADD, K_SUB, K_SWAP
  } kind_t;

  typedef enum logic [2:0] {
    RK_NONE, RK_ZDEN, RK_NEG, RK_OVF, RK_ORDER, RK_ONE, RK_VAL
  } res_kind_t;

  typedef enum logic [2:0] {
    BR_NONE, BR_CMP, BR_MULZ, BR_ADD, BR_END
  } br_t;

  typedef struct packed {
    kind_t kind;
    sel_t  x;
    sel_t  y;
    sel_t  dst;
    br_t   br;
  } uinstr_t;

  typedef struct packed {
    logic      load;
    logic      go;
    kind_t     kind;
    sel_t      x;
    sel_t      y;
    sel_t      dst;
    logic      out_wr;
    res_kind_t res;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic carry;
    logic t_lt_u;
    logic t_eq_u;
    logic t_zero;
    logic an_zero;
    logic bn_zero;
    logic ad_zero;
    logic bd_zero;
    logic ovf;
  } dp_status_t;

  // micro-program: reduce both operands, cross products (compare ends here), then add/sub or mul/div
  function automatic uinstr_t ucode(input logic [4:0] pc);
    uinstr_t u;
    case (pc)
      5'd0:  u = '{K_GCD,  SEL_AN, SEL_AD, SEL_G1, BR_NONE};
      5'd1:  u = '{K_DIV,  SEL_AN, SEL_G1, SEL_AN, BR_NONE};
      5'd2:  u = '{K_DIV,  SEL_AD, SEL_G1, SEL_AD, BR_NONE};
      5'd3:  u = '{K_GCD,  SEL_BN, SEL_BD, SEL_G1, BR_NONE};
      5'd4:  u = '{K_DIV,  SEL_BN, SEL_G1, SEL_BN, BR_NONE};
      5'd5:  u = '{K_DIV,  SEL_BD, SEL_G1, SEL_BD, BR_NONE};
      5'd6:  u = '{K_MUL,  SEL_AN, SEL_BD, SEL_T,  BR_NONE};
      5'd7:  u = '{K_MUL,  SEL_BN, SEL_AD, SEL_U,  BR_CMP};
      5'd8:  u = '{K_GCD,  SEL_AD, SEL_BD, SEL_G1, BR_NONE};
      5'd9:  u = '{K_DIV,  SEL_BD, SEL_G1, SEL_T,  BR_NONE};
      5'd10: u = '{K_MUL,  SEL_AN, SEL_T,  SEL_T,  BR_NONE};
      5'd11: u = '{K_DIV,  SEL_AD, SEL_G1, SEL_AD, BR_NONE};
      5'd12: u = '{K_MUL,  SEL_BN, SEL_AD, SEL_U,  BR_NONE};
      5'd13: u = '{K_ADD,  SEL_T,  SEL_U,  SEL_T,  BR_ADD};
      5'd14: u = '{K_GCD,  SEL_T,  SEL_G1, SEL_G2, BR_NONE};
      5'd15: u = '{K_DIV,  SEL_T,  SEL_G2, SEL_T,  BR_NONE};
      5'd16: u = '{K_DIV,  SEL_BD, SEL_G2, SEL_BD, BR_NONE};
      5'd17: u = '{K_MUL,  SEL_AD, SEL_BD, SEL_U,  BR_END};
      5'd20: u = '{K_SWAP, SEL_BN, SEL_BD, SEL_BN, BR_MULZ};
      5'd21: u = '{K_GCD,  SEL_AN, SEL_BD, SEL_G1, BR_NONE};
      5'd22: u = '{K_GCD,  SEL_BN, SEL_AD, SEL_G2, BR_NONE};
      5'd23: u = '{K_DIV,  SEL_AN, SEL_G1, SEL_AN, BR_NONE};
      5'd24: u = '{K_DIV,  SEL_BN, SEL_G2, SEL_BN, BR_NONE};
      5'd25: u = '{K_MUL,  SEL_AN, SEL_BN, SEL_T,  BR_NONE};
      5'd26: u = '{K_DIV,  SEL_AD, SEL_G2, SEL_AD, BR_NONE};
      5'd27: u = '{K_DIV,  SEL_BD, SEL_G1, SEL_BD, BR_NONE};
      5'd28: u = '{K_MUL,  SEL_AD, SEL_BD, SEL_U,  BR_END};
      default: u = '{K_MUL, SEL_T, SEL_U, SEL_U, BR_END};
    endcase
    return u;
  endfunction

endpackage

// File: hw/rtl/rational_arithmetic_unit_core.sv
// Exact arithmetic on two non-negative fractions: add, subtract (a-b), multiply, divide
// (a/b) and compare, with the result in lowest terms and a status code for a zero
// denominator, a negative difference or a result wider than WIDTH bits (at most 32).
// One item is worked at a time; in_tready is low from acceptance until the result is
// placed in the output register, which may still be waiting while the next item enters.
// An item's run time is set by the shared bit-serial divider and the binary gcd unit
// (one shift or subtract a cycle); compare takes the fewest steps, add and subtract the
// most. Invalid op codes and zero denominators go from the check state straight to the
// result, with no micro-steps issued.
`include "assert_macros.svh"

module rational_arithmetic_unit_core import rau_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_num, a_den, b_num, b_den
  input  logic [2:0]   in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,  // res_num, res_den, order, zero fill
  output logic [1:0]   out_tuser   // status
);

  cmd_t        cmd;
  dp_status_t  st;
  logic        busy;
  logic [31:0] res_num, res_den;
  logic [1:0]  status, order;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy)
  );

  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .a_num   (in_tdata[31:0]),
    .a_den   (in_tdata[63:32]),
    .b_num   (in_tdata[95:64]),
    .b_den   (in_tdata[127:96]),
    .st      (st),
    .res_num (res_num),
    .res_den (res_den),
    .status  (status),
    .order   (order)
  );

  assign out_tdata = {6'b0, order, res_den, res_num};
  assign out_tuser = status;

  `ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready && busy, "not busy after accept")
  `ASSERT_IMPL(a_go_only_busy, cmd.go || st.done, busy, "datapath active while idle")
  `ASSERT_IMPL(a_err_zero, out_tvalid && out_tuser != ST_OK, out_tdata[63:0] == 64'd0, "error with data")

endmodule

// File: hw/rtl/rau_datapath.sv
module rau_datapath import rau_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output dp_status_t  st,
  output logic [31:0] res_num,
  output logic [31:0] res_den,
  output logic [1:0]  status,
  output logic [1:0]  order
);

  localparam int LW = (WIDTH >= 32) ? 32 : WIDTH;
  localparam logic [DW-1:0] LIMIT = (DW'(1) << LW) - DW'(1);

  logic [DW-1:0] an_r, ad_r, bn_r, bd_r, g1_r, g2_r, t_r, u_r;
  logic [DW-1:0] xval, yval;
  logic          carry_r, done_r;
  sel_t          dst_r;

  logic [DW-1:0] gx_r, gy_r, gx_nxt, gy_nxt, g_res;
  logic [CW-1:0] gk_r, gk_nxt;
  logic          gbusy_r, g_fin;

  logic [DW:0]   rem_r, rem_sh, rem_nxt;
  logic [DW+1:0] diff;
  logic [DW-1:0] quo_r, quo_nxt, dv_r;
  logic [CW-1:0] dcnt_r;
  logic          dbusy_r, d_fin, ge;

  logic [DW:0]   sum;
  logic          wr_en;
  sel_t          wr_dst;
  logic [DW-1:0] wr_val;

  logic [31:0]   res_num_r, res_den_r;
  logic [1:0]    status_r, order_r;

  function automatic logic [DW-1:0] pick(input sel_t s, input logic [DW-1:0] an,
      input logic [DW-1:0] ad, input logic [DW-1:0] bn, input logic [DW-1:0] bd,
      input logic [DW-1:0] g1, input logic [DW-1:0] g2, input logic [DW-1:0] t,
      input logic [DW-1:0] u);
    logic [DW-1:0] v;
    case (s)
      SEL_AN:  v = an;
      SEL_AD:  v = ad;
      SEL_BN:  v = bn;
      SEL_BD:  v = bd;
      SEL_G1:  v = g1;
      SEL_G2:  v = g2;
      SEL_T:   v = t;
      SEL_U:   v = u;
      default: v = u;
    endcase
    return v;
  endfunction

  assign xval = pick(cmd.x, an_r, ad_r, bn_r, bd_r, g1_r, g2_r, t_r, u_r);
  assign yval = pick(cmd.y, an_r, ad_r, bn_r, bd_r, g1_r, g2_r, t_r, u_r);
  assign sum  = (cmd.kind == K_SUB) ? ({1'b0, xval} - {1'b0, yval})
                                    : ({1'b0, xval} + {1'b0, yval});

  // binary gcd, one shift or subtract-and-shift a cycle
  assign g_fin = gbusy_r && (gx_r == '0 || gy_r == '0);
  assign g_res = ((gx_r == '0) ? gy_r : gx_r) << gk_r;

  always_comb begin
    gx_nxt = gx_r;
    gy_nxt = gy_r;
    gk_nxt = gk_r;
    if (!gx_r[0] && !gy_r[0]) begin
      gx_nxt = gx_r >> 1;
      gy_nxt = gy_r >> 1;
      gk_nxt = gk_r + CW'(1);
    end else if (!gx_r[0]) begin
      gx_nxt = gx_r >> 1;
    end else if (!gy_r[0]) begin
      gy_nxt = gy_r >> 1;
    end else if (gx_r >= gy_r) begin
      gx_nxt = (gx_r - gy_r) >> 1;
    end else begin
      gy_nxt = (gy_r - gx_r) >> 1;
    end
  end

  // restoring divider, one quotient bit a cycle
  assign rem_sh  = {rem_r[DW-1:0], quo_r[DW-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, dv_r};
  assign ge      = !diff[DW+1];
  assign rem_nxt = ge ? diff[DW:0] : rem_sh;
  assign quo_nxt = {quo_r[DW-2:0], ge};
  assign d_fin   = dbusy_r && (dcnt_r == CW'(1));

  always_comb begin
    wr_en  = 1'b0;
    wr_dst = cmd.dst;
    wr_val = '0;
    if (cmd.go && cmd.kind == K_MUL) begin
      wr_en  = 1'b1;
      wr_val = DW'(xval[31:0] * yval[31:0]);
    end else if (cmd.go && (cmd.kind == K_ADD || cmd.kind == K_SUB)) begin
      wr_en  = 1'b1;
      wr_val = sum[DW-1:0];
    end else if (g_fin) begin
      wr_en  = 1'b1;
      wr_dst = dst_r;
      wr_val = g_res;
    end else if (d_fin) begin
      wr_en  = 1'b1;
      wr_dst = dst_r;
      wr_val = quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbusy_r <= 1'b0;
      dbusy_r <= 1'b0;
      done_r  <= 1'b0;
      carry_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (cmd.load) begin
        an_r    <= DW'(a_num);
        ad_r    <= DW'(a_den);
        bn_r    <= DW'(b_num);
        bd_r    <= DW'(b_den);
        carry_r <= 1'b0;
      end
      if (cmd.go) begin
        dst_r <= cmd.dst;
        case (cmd.kind)
          K_GCD: begin
            gx_r    <= xval;
            gy_r    <= yval;
            gk_r    <= '0;
            gbusy_r <= 1'b1;
          end
          K_DIV: begin
            rem_r   <= '0;
            quo_r   <= xval;
            dv_r    <= yval;
            dcnt_r  <= CW'(DW);
            dbusy_r <= 1'b1;
          end
          K_ADD: begin
            carry_r <= sum[DW];
            done_r  <= 1'b1;
          end
          K_SUB: begin
            carry_r <= 1'b0;
            done_r  <= 1'b1;
          end
          K_SWAP: begin
            bn_r   <= bd_r;
            bd_r   <= bn_r;
            done_r <= 1'b1;
          end
          default: done_r <= 1'b1;
        endcase
      end
      if (gbusy_r) begin
        if (g_fin) begin
          gbusy_r <= 1'b0;
          done_r  <= 1'b1;
        end else begin
          gx_r <= gx_nxt;
          gy_r <= gy_nxt;
          gk_r <= gk_nxt;
        end
      end
      if (dbusy_r) begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        dcnt_r <= dcnt_r - CW'(1);
        if (d_fin) begin
          dbusy_r <= 1'b0;
          done_r  <= 1'b1;
        end
      end
      if (wr_en) begin
        case (wr_dst)
          SEL_AN:  an_r <= wr_val;
          SEL_AD:  ad_r <= wr_val;
          SEL_BN:  bn_r <= wr_val;
          SEL_BD:  bd_r <= wr_val;
          SEL_G1:  g1_r <= wr_val;
          SEL_G2:  g2_r <= wr_val;
          SEL_T:   t_r  <= wr_val;
          default: u_r  <= wr_val;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_wr) begin
      res_num_r <= '0;
      res_den_r <= '0;
      status_r  <= ST_OK;
      order_r   <= ORD_LT;
      case (cmd.res)
        RK_ZDEN:  status_r <= ST_ZDEN;
        RK_NEG:   status_r <= ST_NEG;
        RK_OVF:   status_r <= ST_OVF;
        RK_ORDER: order_r  <= (t_r < u_r) ? ORD_LT : ((t_r == u_r) ? ORD_EQ : ORD_GT);
        RK_ONE:   res_den_r <= 32'd1;
        RK_VAL: begin
          res_num_r <= t_r[31:0];
          res_den_r <= u_r[31:0];
        end
        default: status_r <= ST_OK;
      endcase
    end
  end

  assign res_num = res_num_r;
  assign res_den = res_den_r;
  assign status  = status_r;
  assign order   = order_r;

  assign st.done    = done_r;
  assign st.carry   = carry_r;
  assign st.t_lt_u  = t_r < u_r;
  assign st.t_eq_u  = t_r == u_r;
  assign st.t_zero  = t_r == '0;
  assign st.an_zero = an_r == '0;
  assign st.bn_zero = bn_r == '0;
  assign st.ad_zero = ad_r == '0;
  assign st.bd_zero = bd_r == '0;
  assign st.ovf     = (t_r > LIMIT) || (u_r > LIMIT);

endmodule

// File: hw/rtl/rau_ctrl.sv
module rau_ctrl import rau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_op,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output cmd_t       cmd,
  output logic       busy
);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_ISSUE, S_WAIT, S_FIN} state_t;

  state_t    state_r;
  logic [2:0] op_r;
  logic [4:0] pc_r;
  res_kind_t rk_r;
  logic      out_valid_r;
  logic      accept, slot_free;
  uinstr_t   ui;

  assign ui        = ucode(pc_r);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign busy       = (state_r != S_IDLE);
  assign cmd.load   = accept;
  assign cmd.go     = (state_r == S_ISSUE);
  assign cmd.kind   = (ui.kind == K_ADD && op_r == OP_SUB) ? K_SUB : ui.kind;
  assign cmd.x      = ui.x;
  assign cmd.y      = ui.y;
  assign cmd.dst    = ui.dst;
  assign cmd.out_wr = (state_r == S_FIN) && slot_free;
  assign cmd.res    = rk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      rk_r        <= RK_NONE;
      op_r        <= OP_ADD;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_op;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          pc_r <= '0;
          if (op_r > OP_CMP) begin
            rk_r    <= RK_NONE;
            state_r <= S_FIN;
          end else if (st.ad_zero || st.bd_zero || (op_r == OP_DIV && st.bn_zero)) begin
            rk_r    <= RK_ZDEN;
            state_r <= S_FIN;
          end else begin
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          if (st.done) begin
            state_r <= S_ISSUE;
            pc_r    <= pc_r + 5'd1;
            case (ui.br)
              BR_CMP: begin
                if (op_r == OP_CMP) begin
                  rk_r    <= RK_ORDER;
                  state_r <= S_FIN;
                end else if (op_r == OP_SUB && st.t_lt_u) begin
                  rk_r    <= RK_NEG;
                  state_r <= S_FIN;
                end else if (op_r == OP_ADD || op_r == OP_SUB) begin
                  pc_r <= PC_ADD;
                end else if (op_r == OP_DIV) begin
                  pc_r <= PC_SWAP;
                end else if (st.an_zero || st.bn_zero) begin
                  rk_r    <= RK_ONE;
                  state_r <= S_FIN;
                end else begin
                  pc_r <= PC_MUL;
                end
              end
              BR_MULZ: begin
                if (st.an_zero || st.bn_zero) begin
                  rk_r    <= RK_ONE;
                  state_r <= S_FIN;
                end
              end
              BR_ADD: begin
                if (st.carry) begin
                  rk_r    <= RK_OVF;
                  state_r <= S_FIN;
                end else if (st.t_zero) begin
                  rk_r    <= RK_ONE;
                  state_r <= S_FIN;
                end
              end
              BR_END: begin
                rk_r    <= st.ovf ? RK_OVF : RK_VAL;
                state_r <= S_FIN;
              end
              default: state_r <= S_ISSUE;
            endcase
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
